FILE: design/size_class_block_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// size class block allocator: assertion macros
// shared property wrappers for the allocator modules
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// checked on every rising edge outside reset, with explicit clock and reset
`define SCBA_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the usual clk_i / rst_ni pair
`define SCBA_ASSERT(lbl, prop, msg) `SCBA_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: design/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg
// types, constants and helper functions of the size class block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package scba_pkg;

  localparam int unsigned HEAP_GRANULES_MAX_DEF = 262144;
  localparam int unsigned NUM_CLASSES_DEF       = 7;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned SIZE_W    = 32;
  localparam int unsigned HG_W      = 19;
  localparam int unsigned CLS_W     = 3;
  localparam int unsigned TAG_W     = 3;
  localparam int unsigned NEED_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CLASS_MAX = 7;

  localparam logic [HG_W-1:0]      HEAP_GRANULES_RST = HG_W'(262144);
  localparam logic [CLS_W-1:0]     CLS_NONE          = 3'd7;
  localparam logic [TAG_W-1:0]     TAG_NONE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_GRANULES = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOCATED  = 3'd0,
    ST_FREED      = 3'd1,
    ST_NEEDS_MAP  = 3'd2,
    ST_EXHAUSTED  = 3'd3,
    ST_OUTSIDE    = 3'd4,
    ST_BAD_HEADER = 3'd5,
    ST_NULL       = 3'd6
  } status_e;

  // free stack update requests
  typedef struct packed {
    logic             pop;
    logic             push;
    logic             bump;
    logic [CLS_W-1:0] cls;
  } stk_ctrl_t;

  // smallest class of 16 << c bytes that holds size, CLS_NONE above 1024
  function automatic logic [CLS_W-1:0] size_to_class(input logic [SIZE_W-1:0] size);
    logic [CLS_W-1:0] cls;
    logic             found;
    cls   = CLS_NONE;
    found = 1'b0;
    for (int c = 0; c < CLASS_MAX; c++) begin
      if (!found && size <= (SIZE_W'(16) << c)) begin
        cls   = CLS_W'(c);
        found = 1'b1;
      end
    end
    return cls;
  endfunction

  // granules per block: class bytes plus header, rounded to 16
  function automatic logic [NEED_W-1:0] class_need(input logic [CLS_W-1:0] cls);
    return (NEED_W'(1) << cls) + NEED_W'(1);
  endfunction

endpackage

`default_nettype wire

FILE: design/scba_tag_ram.sv
// ----------------------------------------------------------------------------
// scba_tag_ram
// per-granule class tag and free link memory, cleared by a sweep after reset
// ----------------------------------------------------------------------------
`default_nettype none

`include "size_class_block_allocator_top_defines.svh"

module scba_tag_ram import scba_pkg::*; #(
  parameter int unsigned HEAP_GRANULES_MAX = HEAP_GRANULES_MAX_DEF,
  localparam int unsigned GW     = $clog2(HEAP_GRANULES_MAX),
  localparam int unsigned DATA_W = TAG_W + GW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              re_i,
  input  wire logic [GW-1:0]     raddr_i,
  output logic      [DATA_W-1:0] rdata_o,
  input  wire logic              we_i,
  input  wire logic [GW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic                   ready_o
);

  localparam int unsigned CLR_W = GW + 1;
  localparam logic [CLR_W-1:0] CLR_END = CLR_W'(HEAP_GRANULES_MAX);

  logic [DATA_W-1:0] mem_q [HEAP_GRANULES_MAX];
  logic [DATA_W-1:0] rdata_q;
  logic [CLR_W-1:0]  clr_q, clr_d;
  logic              clr_busy;
  logic              wen;
  logic [GW-1:0]     wa;
  logic [DATA_W-1:0] wd;

  assign clr_busy = (clr_q != CLR_END);
  assign clr_d    = clr_busy ? clr_q + CLR_W'(1) : clr_q;

  // the sweep owns the write port until every entry holds a zero tag
  assign wen = clr_busy | we_i;
  assign wa  = clr_busy ? clr_q[GW-1:0] : waddr_i;
  assign wd  = clr_busy ? '0 : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[wa] <= wd;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_busy;

  `SCBA_ASSERT(a_no_access_while_clearing, (re_i || we_i) |-> !clr_busy, "tag ram accessed during clear sweep")

endmodule

`default_nettype wire

FILE: design/scba_stack_regs.sv
// ----------------------------------------------------------------------------
// scba_stack_regs
// per-class free stack heads and counts, and the heap bump pointer
// ----------------------------------------------------------------------------
`default_nettype none

`include "size_class_block_allocator_top_defines.svh"

module scba_stack_regs import scba_pkg::*; #(
  parameter int unsigned HEAP_GRANULES_MAX = HEAP_GRANULES_MAX_DEF,
  parameter int unsigned NUM_CLASSES       = NUM_CLASSES_DEF,
  localparam int unsigned GW    = $clog2(HEAP_GRANULES_MAX),
  localparam int unsigned CNT_W = GW + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire stk_ctrl_t        ctrl_i,
  input  wire logic [GW-1:0]    g_i,
  input  wire logic [GW-1:0]    link_i,
  input  wire logic [CNT_W-1:0] bump_nxt_i,
  output logic      [GW-1:0]    head_o [NUM_CLASSES],
  output logic                  cnt_nz_o [NUM_CLASSES],
  output logic      [CNT_W-1:0] bump_o
);

  localparam int unsigned CI_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic [GW-1:0]    head_q [NUM_CLASSES];
  logic [GW-1:0]    head_d [NUM_CLASSES];
  logic [CNT_W-1:0] cnt_q  [NUM_CLASSES];
  logic [CNT_W-1:0] cnt_d  [NUM_CLASSES];
  logic [CNT_W-1:0] bump_q, bump_d;
  logic [CI_W-1:0]  ci;

  assign ci = ctrl_i.cls[CI_W-1:0];

  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    bump_d = bump_q;
    if (ctrl_i.pop) begin
      cnt_d[ci]  = cnt_q[ci] - CNT_W'(1);
      // last block leaves an empty stack with a zero head
      head_d[ci] = (cnt_q[ci] == CNT_W'(1)) ? '0 : link_i;
    end
    if (ctrl_i.push) begin
      cnt_d[ci]  = cnt_q[ci] + CNT_W'(1);
      head_d[ci] = g_i;
    end
    if (ctrl_i.bump) begin
      bump_d = bump_nxt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
      bump_q <= '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      bump_q <= bump_d;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_o[c]   = head_q[c];
      cnt_nz_o[c] = (cnt_q[c] != '0);
    end
  end

  assign bump_o = bump_q;

  `SCBA_ASSERT(a_pop_needs_block, ctrl_i.pop |-> (!ctrl_i.push && cnt_q[ci] != '0), "pop from an empty free stack")

endmodule

`default_nettype wire

FILE: design/size_class_block_allocator_top.sv
// ----------------------------------------------------------------------------
// size_class_block_allocator_top
// size class allocator with per-class free stacks and a bump heap
// ----------------------------------------------------------------------------
// Usage
//   cfg channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 heap_base,
//   1 heap_granules) and cfg_data_i; ready is always high. Write only while
//   no transaction is in flight.
//   in channel: op_i, req_size_i, free_addr_i, taken when in_valid_i is high
//   and in_stall_o is low. out channel: status_o, block_addr_o, size_class_o,
//   taken when out_valid_o is high and out_stall_i is low.
//   Each request gives exactly one result, after its address and write cycles.
//   One request is worked on at a time: the next is taken only as it finishes,
//   set by the read then write of the tag/link memory on a single port pair.
//   The result sits in an output register, so the next request is accepted
//   while it waits; a stalled result holds the block in its write cycle.
//   After reset the tag memory is swept to zero, one entry a cycle, over all
//   HEAP_GRANULES_MAX entries (262144 by default); in_stall_o stays high
//   until the sweep ends.
// ----------------------------------------------------------------------------
`default_nettype none

`include "size_class_block_allocator_top_defines.svh"

module size_class_block_allocator_top import scba_pkg::*; #(
  parameter int unsigned HEAP_GRANULES_MAX = HEAP_GRANULES_MAX_DEF,
  parameter int unsigned NUM_CLASSES       = NUM_CLASSES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ADDR_W-1:0]    cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 op_i,
  input  wire logic [SIZE_W-1:0]    req_size_i,
  input  wire logic [ADDR_W-1:0]    free_addr_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [2:0]           status_o,
  output logic      [ADDR_W-1:0]    block_addr_o,
  output logic      [CLS_W-1:0]     size_class_o
);

  localparam int unsigned GW     = $clog2(HEAP_GRANULES_MAX);
  localparam int unsigned CNT_W  = GW + 1;
  localparam int unsigned UW     = (HG_W > CNT_W) ? HG_W : CNT_W;
  localparam int unsigned DATA_W = TAG_W + GW;
  localparam int unsigned CI_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned OFF_W  = ADDR_W - 4;

  typedef enum logic [1:0] {S_IDLE, S_ADDR, S_RMW} state_e;
  typedef enum logic [1:0] {K_DONE, K_POP, K_BUMP, K_FREE} kind_e;

  // configuration
  logic [ADDR_W-1:0] heap_base_q;
  logic [HG_W-1:0]   heap_gran_q;
  logic [UW-1:0]     usable;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
      heap_gran_q <= HEAP_GRANULES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HEAP_BASE:     heap_base_q <= cfg_data_i;
        CFG_HEAP_GRANULES: heap_gran_q <= cfg_data_i[HG_W-1:0];
        default: ;
      endcase
    end
  end

  assign usable = (UW'(heap_gran_q) > UW'(HEAP_GRANULES_MAX)) ? UW'(HEAP_GRANULES_MAX)
                                                              : UW'(heap_gran_q);

  // control and item registers
  state_e            state_q, state_d;
  logic              op_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] faddr_q;
  logic              in_acc, fin, can_finish, ram_ready;

  // context handed from the address cycle to the write cycle
  kind_e             kind_q, kind_d;
  status_e           cst_q, cst_d;
  logic [CLS_W-1:0]  ccls_q, ccls_d;
  logic [GW-1:0]     cg_q, cg_d;
  logic [CNT_W-1:0]  cnxt_q, cnxt_d;

  // result register
  logic              out_valid_q, out_valid_d;
  status_e           ost_q, ost_d;
  logic [ADDR_W-1:0] oaddr_q, oaddr_d;
  logic [CLS_W-1:0]  ocls_q, ocls_d;

  // memory and stacks
  logic              tram_re, tram_we;
  logic [DATA_W-1:0] tram_rdata, tram_wdata;
  logic [TAG_W-1:0]  rd_tag;
  logic [GW-1:0]     rd_link;
  stk_ctrl_t         stk_ctrl;
  logic [GW-1:0]     head [NUM_CLASSES];
  logic              cnt_nz [NUM_CLASSES];
  logic [CNT_W-1:0]  bump;

  assign can_finish = !out_valid_q || !out_stall_i;
  assign fin        = (state_q == S_RMW) && can_finish;
  assign in_stall_o = !(ram_ready && ((state_q == S_IDLE) || fin));
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_ADDR;
      S_ADDR:  state_d = S_RMW;
      S_RMW:   if (fin) state_d = in_acc ? S_ADDR : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= op_i;
      size_q  <= req_size_i;
      faddr_q <= free_addr_i;
    end
    if (state_q == S_ADDR) begin
      kind_q <= kind_d;
      cst_q  <= cst_d;
      ccls_q <= ccls_d;
      cg_q   <= cg_d;
      cnxt_q <= cnxt_d;
    end
    if (fin) begin
      ost_q   <= ost_d;
      oaddr_q <= oaddr_d;
      ocls_q  <= ocls_d;
    end
  end

  // address cycle: class choice or heap range check, then the memory read
  logic [CLS_W-1:0] a_cls;
  logic [CI_W-1:0]  a_ci;
  logic [UW:0]      a_nxt;
  logic [ADDR_W:0]  f_diff;
  logic [ADDR_W-1:0] f_off;
  logic             f_outside;

  always_comb begin
    a_cls     = size_to_class(size_q);
    a_ci      = a_cls[CI_W-1:0];
    a_nxt     = (UW+1)'(bump) + (UW+1)'(class_need(a_cls));
    f_diff    = {1'b0, faddr_q} - {1'b0, heap_base_q[ADDR_W-1:4], 4'b0000};
    f_off     = f_diff[ADDR_W-1:0];
    f_outside = f_diff[ADDR_W] || (f_off[ADDR_W-1:3] == '0)
             || (f_off[ADDR_W-1:4] >= OFF_W'(usable));

    kind_d = K_DONE;
    cst_d  = ST_NEEDS_MAP;
    ccls_d = a_cls;
    cg_d   = head[a_ci];
    cnxt_d = CNT_W'(a_nxt);
    if (!op_q) begin
      if (a_cls >= CLS_W'(NUM_CLASSES)) begin
        cst_d = ST_NEEDS_MAP;
      end else if (cnt_nz[a_ci]) begin
        kind_d = K_POP;
      end else if (a_nxt > (UW+1)'(usable)) begin
        cst_d = ST_EXHAUSTED;
      end else begin
        kind_d = K_BUMP;
        cg_d   = bump[GW-1:0];
      end
    end else begin
      cg_d = f_off[GW+3:4];
      if (faddr_q == '0) begin
        cst_d = ST_NULL;
      end else if (f_outside) begin
        cst_d = ST_OUTSIDE;
      end else if (f_off[3:0] != 4'b1000) begin
        // header not on a granule boundary
        cst_d = ST_BAD_HEADER;
      end else begin
        kind_d = K_FREE;
      end
    end
  end

  assign tram_re = (state_q == S_ADDR) && ((kind_d == K_POP) || (kind_d == K_FREE));

  // write cycle: tag check, stack update, tag/link write back
  logic [CLS_W-1:0] f_cls;
  logic             tag_bad;

  assign rd_tag  = tram_rdata[DATA_W-1:GW];
  assign rd_link = tram_rdata[GW-1:0];
  assign tag_bad = (rd_tag == TAG_NONE) || (rd_tag > TAG_W'(NUM_CLASSES));
  assign f_cls   = CLS_W'(rd_tag - TAG_W'(1));

  always_comb begin
    ost_d      = cst_q;
    oaddr_d    = '0;
    ocls_d     = CLS_NONE;
    tram_we    = 1'b0;
    tram_wdata = {TAG_W'(ccls_q) + TAG_W'(1), GW'(0)};
    stk_ctrl   = '{pop: 1'b0, push: 1'b0, bump: 1'b0, cls: ccls_q};
    case (kind_q)
      K_POP, K_BUMP: begin
        ost_d         = ST_ALLOCATED;
        oaddr_d       = {heap_base_q[ADDR_W-1:4] + OFF_W'(cg_q), 4'b1000};
        ocls_d        = ccls_q;
        tram_we       = fin;
        stk_ctrl.pop  = fin && (kind_q == K_POP);
        stk_ctrl.bump = fin && (kind_q == K_BUMP);
      end
      K_FREE: begin
        if (tag_bad) begin
          ost_d = ST_BAD_HEADER;
        end else begin
          ost_d         = ST_FREED;
          ocls_d        = f_cls;
          tram_we       = fin;
          tram_wdata    = {TAG_NONE, head[f_cls[CI_W-1:0]]};
          stk_ctrl.push = fin;
          stk_ctrl.cls  = f_cls;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = fin || (out_valid_q && out_stall_i);

  scba_tag_ram #(
    .HEAP_GRANULES_MAX(HEAP_GRANULES_MAX)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .re_i   (tram_re),
    .raddr_i(cg_d),
    .rdata_o(tram_rdata),
    .we_i   (tram_we),
    .waddr_i(cg_q),
    .wdata_i(tram_wdata),
    .ready_o(ram_ready)
  );

  scba_stack_regs #(
    .HEAP_GRANULES_MAX(HEAP_GRANULES_MAX),
    .NUM_CLASSES      (NUM_CLASSES)
  ) u_stack_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (stk_ctrl),
    .g_i       (cg_q),
    .link_i    (rd_link),
    .bump_nxt_i(cnxt_q),
    .head_o    (head),
    .cnt_nz_o  (cnt_nz),
    .bump_o    (bump)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = ost_q;
  assign block_addr_o = oaddr_q;
  assign size_class_o = ocls_q;

  `SCBA_ASSERT(a_addr_then_rmw, state_q == S_ADDR |=> state_q == S_RMW, "address cycle not followed by write cycle")
  `SCBA_ASSERT(a_result_from_rmw, $rose(out_valid_o) |-> $past(state_q) == S_RMW, "result without a write cycle")
  `SCBA_ASSERT(a_one_stack_update, $onehot0({stk_ctrl.pop, stk_ctrl.push, stk_ctrl.bump}), "more than one stack update at once")

endmodule

`default_nettype wire
